// ===== hdl/tksd_pkg.sv =====
package tksd_pkg;

    // CSI parameter bytes that feed the number; later ones are ignored.
    localparam int PARAM_BYTES = 15;
    localparam int PCNT_W      = $clog2(PARAM_BYTES + 1);

    // Result queue; the depth must be a power of two so that the pointers wrap.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [4:0] KEY_CHAR  = 5'd0;
    localparam logic [4:0] KEY_ESC   = 5'd1;
    localparam logic [4:0] KEY_ENTER = 5'd2;
    localparam logic [4:0] KEY_TAB   = 5'd3;
    localparam logic [4:0] KEY_BS    = 5'd4;
    localparam logic [4:0] KEY_CTRL  = 5'd5;
    localparam logic [4:0] KEY_UP    = 5'd6;
    localparam logic [4:0] KEY_DOWN  = 5'd7;
    localparam logic [4:0] KEY_RIGHT = 5'd8;
    localparam logic [4:0] KEY_LEFT  = 5'd9;
    localparam logic [4:0] KEY_HOME  = 5'd10;
    localparam logic [4:0] KEY_END   = 5'd11;
    localparam logic [4:0] KEY_BTAB  = 5'd12;
    localparam logic [4:0] KEY_INS   = 5'd13;
    localparam logic [4:0] KEY_DEL   = 5'd14;
    localparam logic [4:0] KEY_PGUP  = 5'd15;
    localparam logic [4:0] KEY_PGDN  = 5'd16;
    localparam logic [4:0] KEY_F1    = 5'd17;
    localparam logic [4:0] KEY_F2    = 5'd18;
    localparam logic [4:0] KEY_F3    = 5'd19;
    localparam logic [4:0] KEY_F4    = 5'd20;
    localparam logic [4:0] KEY_F5    = 5'd21;
    localparam logic [4:0] KEY_F6    = 5'd22;
    localparam logic [4:0] KEY_F7    = 5'd23;
    localparam logic [4:0] KEY_F8    = 5'd24;
    localparam logic [4:0] KEY_F9    = 5'd25;
    localparam logic [4:0] KEY_F10   = 5'd26;
    localparam logic [4:0] KEY_F11   = 5'd27;
    localparam logic [4:0] KEY_F12   = 5'd28;

    typedef struct packed {
        logic [4:0]  key;
        logic [31:0] char_bytes;
        logic [2:0]  char_len;
        logic        last;
    } result_t;

    // Everything one input item produces: zero, one or two results.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } decode_out_t;

endpackage

// ===== hdl/terminal_key_sequence_decoder_core.sv =====
// Terminal key decoder: each stream transaction in carries one received byte
// (tuser low) or an inter-byte timeout (tuser high); each transaction out is one
// decoded key, and tlast marks the final key caused by an input transaction.
// An input is registered, then decoded together with the escape, CSI and
// UTF-8 state, and its zero, one or two keys go into a four-entry result
// queue whose head drives the output. One input is taken every cycle while the
// queue has room for two keys; an input that yields two keys (ESC followed by
// the decoded stray byte) leaves the output one key at a time, at one key per
// cycle while the output is ready.
module terminal_key_sequence_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // key[4:0], char_bytes[36:5], char_len[39:37]
    output logic        m_axis_tlast    // last
);

    logic                  in_valid_reg;
    logic                  in_timeout_reg;
    logic [7:0]            in_byte_reg;
    logic                  fire;
    logic                  room;
    tksd_pkg::decode_out_t dec;
    tksd_pkg::result_t     head;

    assign fire          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_timeout_reg <= s_axis_tuser;
            in_byte_reg    <= s_axis_tdata;
        end
    end

    tksd_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .timeout   (in_timeout_reg),
        .data_byte (in_byte_reg),
        .dec       (dec)
    );

    tksd_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (fire),
        .wr        (dec),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    assign m_axis_tdata = {head.char_len, head.char_bytes, head.key};
    assign m_axis_tlast = head.last;

endmodule

// ===== hdl/tksd_decoder.sv =====
module tksd_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic                 timeout,
    input  logic [7:0]           data_byte,
    output tksd_pkg::decode_out_t dec
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_ESC,
        MODE_SS3,
        MODE_CSI,
        MODE_UTF8
    } mode_t;

    typedef enum logic [1:0] {
        PH_BLANK,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    localparam logic [7:0] BYTE_ESC      = 8'd27;
    localparam logic [7:0] BYTE_DEL      = 8'd127;
    localparam logic [7:0] BYTE_BS       = 8'd8;
    localparam logic [7:0] BYTE_TAB      = 8'd9;
    localparam logic [7:0] BYTE_LF       = 8'd10;
    localparam logic [7:0] BYTE_CR       = 8'd13;
    localparam logic [7:0] BYTE_SPACE    = 8'd32;
    localparam logic [7:0] BYTE_PLUS     = 8'h2B;
    localparam logic [7:0] BYTE_MINUS    = 8'h2D;
    localparam logic [7:0] BYTE_ZERO     = 8'h30;
    localparam logic [7:0] BYTE_NINE     = 8'h39;
    localparam logic [7:0] BYTE_SS3      = 8'h4F;
    localparam logic [7:0] BYTE_CSI      = 8'h5B;
    localparam logic [7:0] FINAL_LO      = 8'h40;
    localparam logic [7:0] FINAL_HI      = 8'h7E;
    localparam logic [7:0] BYTE_TILDE    = 8'h7E;
    localparam logic [7:0] CTRL_OFFSET   = 8'd64;
    localparam logic [7:0] ASCII_LIMIT   = 8'h80;
    localparam logic [7:0] MASK_LEAD2    = 8'hE0;
    localparam logic [7:0] LEAD2         = 8'hC0;
    localparam logic [7:0] MASK_LEAD3    = 8'hF0;
    localparam logic [7:0] LEAD3         = 8'hE0;
    localparam logic [7:0] MASK_LEAD4    = 8'hF8;
    localparam logic [7:0] LEAD4         = 8'hF0;

    function automatic tksd_pkg::result_t named_key(input logic [4:0] k);
        tksd_pkg::result_t r;
        r            = '0;
        r.key        = k;
        return r;
    endfunction

    function automatic logic [4:0] ss3_key(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h50:   k = tksd_pkg::KEY_F1;     // P
            8'h51:   k = tksd_pkg::KEY_F2;     // Q
            8'h52:   k = tksd_pkg::KEY_F3;     // R
            8'h53:   k = tksd_pkg::KEY_F4;     // S
            8'h41:   k = tksd_pkg::KEY_UP;     // A
            8'h42:   k = tksd_pkg::KEY_DOWN;   // B
            8'h43:   k = tksd_pkg::KEY_RIGHT;  // C
            8'h44:   k = tksd_pkg::KEY_LEFT;   // D
            8'h48:   k = tksd_pkg::KEY_HOME;   // H
            8'h46:   k = tksd_pkg::KEY_END;    // F
            default: k = tksd_pkg::KEY_ESC;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] tilde_key(input logic [7:0] v, input logic neg);
        logic [4:0] k;
        case (v)
            8'd1, 8'd7: k = tksd_pkg::KEY_HOME;
            8'd4, 8'd8: k = tksd_pkg::KEY_END;
            8'd2:       k = tksd_pkg::KEY_INS;
            8'd3:       k = tksd_pkg::KEY_DEL;
            8'd5:       k = tksd_pkg::KEY_PGUP;
            8'd6:       k = tksd_pkg::KEY_PGDN;
            8'd11:      k = tksd_pkg::KEY_F1;
            8'd12:      k = tksd_pkg::KEY_F2;
            8'd13:      k = tksd_pkg::KEY_F3;
            8'd14:      k = tksd_pkg::KEY_F4;
            8'd15:      k = tksd_pkg::KEY_F5;
            8'd17:      k = tksd_pkg::KEY_F6;
            8'd18:      k = tksd_pkg::KEY_F7;
            8'd19:      k = tksd_pkg::KEY_F8;
            8'd20:      k = tksd_pkg::KEY_F9;
            8'd21:      k = tksd_pkg::KEY_F10;
            8'd23:      k = tksd_pkg::KEY_F11;
            8'd24:      k = tksd_pkg::KEY_F12;
            default:    k = tksd_pkg::KEY_ESC;
        endcase
        if (neg)
        begin
            k = tksd_pkg::KEY_ESC;
        end
        return k;
    endfunction

    function automatic logic [4:0] csi_key(input logic [7:0] c, input logic [7:0] v,
                                           input logic neg);
        logic [4:0] k;
        case (c)
            8'h41:      k = tksd_pkg::KEY_UP;     // A
            8'h42:      k = tksd_pkg::KEY_DOWN;   // B
            8'h43:      k = tksd_pkg::KEY_RIGHT;  // C
            8'h44:      k = tksd_pkg::KEY_LEFT;   // D
            8'h48:      k = tksd_pkg::KEY_HOME;   // H
            8'h46:      k = tksd_pkg::KEY_END;    // F
            8'h5A:      k = tksd_pkg::KEY_BTAB;   // Z
            BYTE_TILDE: k = tilde_key(v, neg);
            default:    k = tksd_pkg::KEY_ESC;
        endcase
        return k;
    endfunction

    mode_t                        mode_reg, mode_next;
    logic [tksd_pkg::PCNT_W-1:0]  pcount_reg, pcount_next;
    logic [7:0]                   pvalue_reg, pvalue_next;
    phase_t                       phase_reg, phase_next;
    logic                         negative_reg, negative_next;
    logic [31:0]                  utf8_bytes_reg, utf8_bytes_next;
    logic [1:0]                   utf8_rem_reg, utf8_rem_next;
    logic [2:0]                   utf8_count_reg, utf8_count_next;

    // Decode of the byte as if the block were idle.
    tksd_pkg::result_t id_res;
    logic              id_emit;
    mode_t             id_mode;
    logic [1:0]        id_rem;

    always_comb
    begin
        id_res            = '0;
        id_res.key        = tksd_pkg::KEY_CHAR;
        id_res.char_bytes = {24'd0, data_byte};
        id_res.char_len   = 3'd1;
        id_emit           = 1'b1;
        id_mode           = MODE_IDLE;
        id_rem            = 2'd0;
        if (data_byte == BYTE_ESC)
        begin
            id_emit = 1'b0;
            id_mode = MODE_ESC;
        end
        else if (data_byte == BYTE_CR || data_byte == BYTE_LF)
        begin
            id_res = named_key(tksd_pkg::KEY_ENTER);
        end
        else if (data_byte == BYTE_TAB)
        begin
            id_res = named_key(tksd_pkg::KEY_TAB);
        end
        else if (data_byte == BYTE_BS || data_byte == BYTE_DEL)
        begin
            id_res = named_key(tksd_pkg::KEY_BS);
        end
        else if (data_byte < BYTE_SPACE)
        begin
            id_res.key        = tksd_pkg::KEY_CTRL;
            id_res.char_bytes = {24'd0, data_byte + CTRL_OFFSET};
        end
        else if (data_byte < ASCII_LIMIT)
        begin
            id_res.key = tksd_pkg::KEY_CHAR;
        end
        else if ((data_byte & MASK_LEAD2) == LEAD2)
        begin
            id_emit = 1'b0;
            id_mode = MODE_UTF8;
            id_rem  = 2'd1;
        end
        else if ((data_byte & MASK_LEAD3) == LEAD3)
        begin
            id_emit = 1'b0;
            id_mode = MODE_UTF8;
            id_rem  = 2'd2;
        end
        else if ((data_byte & MASK_LEAD4) == LEAD4)
        begin
            id_emit = 1'b0;
            id_mode = MODE_UTF8;
            id_rem  = 2'd3;
        end
    end

    // CSI number, fed one parameter byte at a time.
    logic       is_digit, is_blank, is_sign;
    logic [11:0] scaled;
    logic [7:0]  nf_value;
    phase_t      nf_phase;
    logic        nf_negative;

    assign is_digit = (data_byte >= BYTE_ZERO) && (data_byte <= BYTE_NINE);
    assign is_blank = (data_byte == BYTE_SPACE) ||
                      ((data_byte >= BYTE_TAB) && (data_byte <= BYTE_CR));
    assign is_sign  = (data_byte == BYTE_PLUS) || (data_byte == BYTE_MINUS);
    assign scaled   = {4'd0, pvalue_reg} * 12'd10 + {8'd0, data_byte[3:0]};

    always_comb
    begin
        nf_value    = pvalue_reg;
        nf_phase    = phase_reg;
        nf_negative = negative_reg;
        if (phase_reg == PH_BLANK && is_blank)
        begin
            nf_phase = PH_BLANK;
        end
        else if (phase_reg == PH_BLANK && is_sign)
        begin
            nf_negative = (data_byte == BYTE_MINUS);
            nf_phase    = PH_DIGITS;
        end
        else if (phase_reg == PH_BLANK || phase_reg == PH_DIGITS)
        begin
            if (is_digit)
            begin
                nf_phase = PH_DIGITS;
                nf_value = (scaled > 12'd255) ? 8'd255 : scaled[7:0];
            end
            else
            begin
                nf_phase = PH_DONE;
            end
        end
    end

    // Continuation byte merged into the character being gathered.
    logic [31:0] u_bytes;
    logic [2:0]  u_count;
    logic [1:0]  u_rem;
    logic        u_take;

    assign u_take  = !timeout && (utf8_count_reg < 3'd4);
    assign u_bytes = utf8_bytes_reg | ({24'd0, data_byte} << {utf8_count_reg[1:0], 3'b000});
    assign u_count = utf8_count_reg + 3'd1;
    assign u_rem   = (utf8_rem_reg != 2'd0) ? utf8_rem_reg - 2'd1 : 2'd0;

    tksd_pkg::result_t first_res, second_res;
    logic [1:0]        n;
    logic [4:0]        ss3_k;

    assign ss3_k = ss3_key(data_byte);

    always_comb
    begin
        mode_next       = mode_reg;
        pcount_next     = pcount_reg;
        pvalue_next     = pvalue_reg;
        phase_next      = phase_reg;
        negative_next   = negative_reg;
        utf8_bytes_next = utf8_bytes_reg;
        utf8_rem_next   = utf8_rem_reg;
        utf8_count_next = utf8_count_reg;
        first_res       = named_key(tksd_pkg::KEY_ESC);
        second_res      = id_res;
        n               = 2'd0;

        case (mode_reg)
            MODE_ESC:
            begin
                mode_next = MODE_IDLE;
                if (timeout)
                begin
                    n = 2'd1;
                end
                else if (data_byte == BYTE_SS3)
                begin
                    mode_next = MODE_SS3;
                end
                else if (data_byte == BYTE_CSI)
                begin
                    mode_next     = MODE_CSI;
                    pcount_next   = '0;
                    pvalue_next   = 8'd0;
                    phase_next    = PH_BLANK;
                    negative_next = 1'b0;
                end
                else
                begin
                    // The stray byte is decoded again after the ESC.
                    n         = {id_emit, !id_emit};
                    mode_next = id_mode;
                end
            end
            MODE_SS3:
            begin
                mode_next = MODE_IDLE;
                if (timeout)
                begin
                    n = 2'd1;
                end
                else if (ss3_k != tksd_pkg::KEY_ESC)
                begin
                    first_res = named_key(ss3_k);
                    n         = 2'd1;
                end
                else
                begin
                    n         = {id_emit, !id_emit};
                    mode_next = id_mode;
                end
            end
            MODE_CSI:
            begin
                if (timeout)
                begin
                    mode_next = MODE_IDLE;
                    n         = 2'd1;
                end
                else if (data_byte >= FINAL_LO && data_byte <= FINAL_HI)
                begin
                    mode_next = MODE_IDLE;
                    first_res = named_key(csi_key(data_byte, pvalue_reg, negative_reg));
                    n         = 2'd1;
                end
                else if (pcount_reg < tksd_pkg::PCNT_W'(tksd_pkg::PARAM_BYTES))
                begin
                    pcount_next   = pcount_reg + 1'b1;
                    pvalue_next   = nf_value;
                    phase_next    = nf_phase;
                    negative_next = nf_negative;
                end
            end
            MODE_UTF8:
            begin
                if (u_take && u_rem != 2'd0)
                begin
                    utf8_bytes_next = u_bytes;
                    utf8_count_next = u_count;
                    utf8_rem_next   = u_rem;
                end
                else
                begin
                    mode_next            = MODE_IDLE;
                    first_res            = '0;
                    first_res.key        = tksd_pkg::KEY_CHAR;
                    first_res.char_bytes = u_take ? u_bytes : utf8_bytes_reg;
                    first_res.char_len   = u_take ? u_count : utf8_count_reg;
                    n                    = 2'd1;
                    utf8_bytes_next      = 32'd0;
                    utf8_rem_next        = 2'd0;
                    utf8_count_next      = 3'd0;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                if (!timeout)
                begin
                    first_res = id_res;
                    n         = {1'b0, id_emit};
                    mode_next = id_mode;
                end
            end
        endcase

        // A lead byte seen through the idle decode starts a new character.
        if (mode_reg != MODE_UTF8 && mode_reg != MODE_CSI && !timeout &&
            mode_next == MODE_UTF8)
        begin
            utf8_bytes_next = {24'd0, data_byte};
            utf8_rem_next   = id_rem;
            utf8_count_next = 3'd1;
        end

        first_res.last  = (n == 2'd1);
        second_res.last = 1'b1;
    end

    assign dec.count  = n;
    assign dec.first  = first_res;
    assign dec.second = second_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            pcount_reg     <= '0;
            pvalue_reg     <= 8'd0;
            phase_reg      <= PH_BLANK;
            negative_reg   <= 1'b0;
            utf8_bytes_reg <= 32'd0;
            utf8_rem_reg   <= 2'd0;
            utf8_count_reg <= 3'd0;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            pcount_reg     <= pcount_next;
            pvalue_reg     <= pvalue_next;
            phase_reg      <= phase_next;
            negative_reg   <= negative_next;
            utf8_bytes_reg <= utf8_bytes_next;
            utf8_rem_reg   <= utf8_rem_next;
            utf8_count_reg <= utf8_count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) n != 2'd3)
        else $error("decoder produced more than two results");

    assert property (@(posedge clk) disable iff (!rst_n)
        (n == 2'd2) |-> (mode_reg == MODE_ESC || mode_reg == MODE_SS3))
        else $error("two results outside an ESC or SS3 sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        pcount_reg <= tksd_pkg::PCNT_W'(tksd_pkg::PARAM_BYTES))
        else $error("CSI parameter count beyond its limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_UTF8) |-> (utf8_count_reg >= 3'd1 && utf8_count_reg <= 3'd3 &&
                                     utf8_rem_reg != 2'd0))
        else $error("UTF-8 gathering state is inconsistent");

endmodule

// ===== hdl/tksd_result_fifo.sv =====
module tksd_result_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  tksd_pkg::decode_out_t wr,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tksd_pkg::result_t     out_data
);

    tksd_pkg::result_t                 mem_reg [tksd_pkg::RES_DEPTH];
    logic [tksd_pkg::RES_PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg, wr_ptr_inc;
    logic [tksd_pkg::RES_CNT_W-1:0]    count_reg, count_next;
    logic                              pop;
    logic [1:0]                        push_n;

    assign push_n     = wr_en ? wr.count : 2'd0;
    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;
    assign count_next = count_reg + tksd_pkg::RES_CNT_W'(push_n)
                        - tksd_pkg::RES_CNT_W'(pop);

    // Room for the worst case of one item, checked before it is decoded.
    assign room      = count_reg <= tksd_pkg::RES_CNT_W'(tksd_pkg::RES_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wr.first;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= wr.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + tksd_pkg::RES_PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + tksd_pkg::RES_PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ({1'b0, count_reg} + {{tksd_pkg::RES_CNT_W - 1{1'b0}}, push_n}
                   <= (tksd_pkg::RES_CNT_W + 1)'(tksd_pkg::RES_DEPTH)))
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!wr_en && !pop) |=> $stable(count_reg))
        else $error("result count changed without a push or pop");

endmodule

// ===== test/terminal_key_sequence_decoder_core_tb.sv =====
module terminal_key_sequence_decoder_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int ITEMS_PER_PASS = 633;

    localparam logic [7:0] ESC_BYTE = 8'd27;
    localparam logic [7:0] DEL_BYTE = 8'd127;

    localparam bit OP_BYTE    = 1'b0;
    localparam bit OP_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_ESC,
        MODE_SS3,
        MODE_CSI,
        MODE_UTF8
    } decode_mode_t;

    typedef enum logic [1:0] {
        NUM_BLANK,
        NUM_DIGITS,
        NUM_DONE
    } number_phase_t;

    class key_scoreboard_t;
        decode_mode_t      mode;
        number_phase_t     num_phase;
        bit                num_negative;
        int                param_count;
        int                param_value;
        logic [31:0]       utf8_bytes;
        int                utf8_left;
        int                utf8_count;
        tksd_pkg::result_t expected_keys[$];
        tksd_pkg::result_t fresh_keys[$];
        int                mismatches;
        int                inputs_seen;
        int                keys_checked;
        logic [31:0]       keys_seen;

        function new();
            mode         = MODE_IDLE;
            num_phase    = NUM_BLANK;
            num_negative = 1'b0;
            param_count  = 0;
            param_value  = 0;
            utf8_bytes   = 32'd0;
            utf8_left    = 0;
            utf8_count   = 0;
            mismatches   = 0;
            inputs_seen  = 0;
            keys_checked = 0;
            keys_seen    = 32'd0;
        endfunction

        function void add_key(logic [4:0] key, logic [31:0] bytes, logic [2:0] len);
            tksd_pkg::result_t r;
            r.key        = key;
            r.char_bytes = bytes;
            r.char_len   = len;
            r.last       = 1'b0;
            fresh_keys.push_back(r);
        endfunction

        // Decoding of a byte seen with no sequence in progress.
        function void decode_plain(logic [7:0] c);
            int follow;
            if (c == ESC_BYTE)
            begin
                mode = MODE_ESC;
                return;
            end
            if (c == 8'd13 || c == 8'd10)
                add_key(tksd_pkg::KEY_ENTER, 32'd0, 3'd0);
            else if (c == 8'd9)
                add_key(tksd_pkg::KEY_TAB, 32'd0, 3'd0);
            else if (c == 8'd8 || c == DEL_BYTE)
                add_key(tksd_pkg::KEY_BS, 32'd0, 3'd0);
            else if (c < 8'd32)
                add_key(tksd_pkg::KEY_CTRL, {24'd0, c + 8'd64}, 3'd1);
            else if (c < 8'h80)
                add_key(tksd_pkg::KEY_CHAR, {24'd0, c}, 3'd1);
            else
            begin
                if ((c & 8'hE0) == 8'hC0)
                    follow = 1;
                else if ((c & 8'hF0) == 8'hE0)
                    follow = 2;
                else if ((c & 8'hF8) == 8'hF0)
                    follow = 3;
                else
                    follow = 0;
                if (follow == 0)
                    add_key(tksd_pkg::KEY_CHAR, {24'd0, c}, 3'd1);
                else
                begin
                    utf8_bytes = {24'd0, c};
                    utf8_left  = follow;
                    utf8_count = 1;
                    mode       = MODE_UTF8;
                end
            end
        endfunction

        function void feed_number(logic [7:0] c);
            int v;
            if (num_phase == NUM_BLANK)
            begin
                if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13))
                    return;
                if (c == "+" || c == "-")
                begin
                    num_negative = (c == "-");
                    num_phase    = NUM_DIGITS;
                    return;
                end
                num_phase = NUM_DIGITS;
            end
            if (num_phase == NUM_DIGITS)
            begin
                if (c >= "0" && c <= "9")
                begin
                    v = param_value * 10 + (int'(c) - 48);
                    param_value = (v > 255) ? 255 : v;
                end
                else
                    num_phase = NUM_DONE;
            end
        endfunction

        function logic [4:0] tilde_key();
            if (num_negative)
                return tksd_pkg::KEY_ESC;
            case (param_value)
                1, 7:    return tksd_pkg::KEY_HOME;
                4, 8:    return tksd_pkg::KEY_END;
                2:       return tksd_pkg::KEY_INS;
                3:       return tksd_pkg::KEY_DEL;
                5:       return tksd_pkg::KEY_PGUP;
                6:       return tksd_pkg::KEY_PGDN;
                11:      return tksd_pkg::KEY_F1;
                12:      return tksd_pkg::KEY_F2;
                13:      return tksd_pkg::KEY_F3;
                14:      return tksd_pkg::KEY_F4;
                15:      return tksd_pkg::KEY_F5;
                17:      return tksd_pkg::KEY_F6;
                18:      return tksd_pkg::KEY_F7;
                19:      return tksd_pkg::KEY_F8;
                20:      return tksd_pkg::KEY_F9;
                21:      return tksd_pkg::KEY_F10;
                23:      return tksd_pkg::KEY_F11;
                24:      return tksd_pkg::KEY_F12;
                default: return tksd_pkg::KEY_ESC;
            endcase
        endfunction

        function logic [4:0] csi_key(logic [7:0] c);
            case (c)
                "A":     return tksd_pkg::KEY_UP;
                "B":     return tksd_pkg::KEY_DOWN;
                "C":     return tksd_pkg::KEY_RIGHT;
                "D":     return tksd_pkg::KEY_LEFT;
                "H":     return tksd_pkg::KEY_HOME;
                "F":     return tksd_pkg::KEY_END;
                "Z":     return tksd_pkg::KEY_BTAB;
                "~":     return tilde_key();
                default: return tksd_pkg::KEY_ESC;
            endcase
        endfunction

        function logic [4:0] ss3_key(logic [7:0] c);
            case (c)
                "P":     return tksd_pkg::KEY_F1;
                "Q":     return tksd_pkg::KEY_F2;
                "R":     return tksd_pkg::KEY_F3;
                "S":     return tksd_pkg::KEY_F4;
                "A":     return tksd_pkg::KEY_UP;
                "B":     return tksd_pkg::KEY_DOWN;
                "C":     return tksd_pkg::KEY_RIGHT;
                "D":     return tksd_pkg::KEY_LEFT;
                "H":     return tksd_pkg::KEY_HOME;
                "F":     return tksd_pkg::KEY_END;
                default: return tksd_pkg::KEY_ESC;
            endcase
        endfunction

        function void note_input(bit op, logic [7:0] c);
            logic [4:0]        k;
            bit                done;
            tksd_pkg::result_t r;
            fresh_keys.delete();
            inputs_seen++;
            case (mode)
                MODE_ESC:
                begin
                    mode = MODE_IDLE;
                    if (op == OP_TIMEOUT)
                        add_key(tksd_pkg::KEY_ESC, 32'd0, 3'd0);
                    else if (c == "O")
                        mode = MODE_SS3;
                    else if (c == "[")
                    begin
                        mode         = MODE_CSI;
                        param_count  = 0;
                        param_value  = 0;
                        num_phase    = NUM_BLANK;
                        num_negative = 1'b0;
                    end
                    else
                    begin
                        // A stray byte ends the escape and is then decoded on its own.
                        add_key(tksd_pkg::KEY_ESC, 32'd0, 3'd0);
                        decode_plain(c);
                    end
                end
                MODE_SS3:
                begin
                    mode = MODE_IDLE;
                    if (op == OP_TIMEOUT)
                        add_key(tksd_pkg::KEY_ESC, 32'd0, 3'd0);
                    else
                    begin
                        k = ss3_key(c);
                        add_key(k, 32'd0, 3'd0);
                        if (k == tksd_pkg::KEY_ESC)
                            decode_plain(c);
                    end
                end
                MODE_CSI:
                begin
                    if (op == OP_TIMEOUT)
                    begin
                        mode = MODE_IDLE;
                        add_key(tksd_pkg::KEY_ESC, 32'd0, 3'd0);
                    end
                    else if (c >= 8'h40 && c <= 8'h7E)
                    begin
                        mode = MODE_IDLE;
                        add_key(csi_key(c), 32'd0, 3'd0);
                    end
                    else if (param_count < tksd_pkg::PARAM_BYTES)
                    begin
                        param_count++;
                        feed_number(c);
                    end
                end
                MODE_UTF8:
                begin
                    done = 1'b1;
                    if (op == OP_BYTE && utf8_count < 4)
                    begin
                        utf8_bytes = utf8_bytes | ({24'd0, c} << (8 * utf8_count));
                        utf8_count++;
                        if (utf8_left > 0)
                            utf8_left--;
                        done = (utf8_left == 0);
                    end
                    if (done)
                    begin
                        mode = MODE_IDLE;
                        add_key(tksd_pkg::KEY_CHAR, utf8_bytes, 3'(utf8_count));
                        utf8_bytes = 32'd0;
                        utf8_left  = 0;
                        utf8_count = 0;
                    end
                end
                default:
                begin
                    mode = MODE_IDLE;
                    if (op == OP_BYTE)
                        decode_plain(c);
                end
            endcase
            foreach (fresh_keys[i])
            begin
                r      = fresh_keys[i];
                r.last = (i == fresh_keys.size() - 1);
                expected_keys.push_back(r);
            end
        endfunction

        function void check_key(tksd_pkg::result_t got);
            tksd_pkg::result_t want;
            if (expected_keys.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected key transaction %0d bytes %h len %0d last %0b",
                             $time, got.key, got.char_bytes, got.char_len, got.last);
                return;
            end
            want = expected_keys.pop_front();
            keys_checked++;
            if (got.key !== want.key || got.char_bytes !== want.char_bytes ||
                got.char_len !== want.char_len || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: key mismatch: expected key %0d bytes %h len %0d last %0b",
                             $time, want.key, want.char_bytes, want.char_len, want.last);
                    $display("%0t:                    got key %0d bytes %h len %0d last %0b",
                             $time, got.key, got.char_bytes, got.char_len, got.last);
                end
            end
            else
                keys_seen[got.key] = 1'b1;
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    key_scoreboard_t   sb;
    tksd_pkg::result_t observed_key;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                stim_items    = 0;
    int                cycle_count   = 0;
    int                tilde_codes [20] = '{1, 2, 3, 4, 5, 6, 7, 8, 11, 12, 13, 14, 15,
                                            17, 18, 19, 20, 21, 23, 24};
    string             ss3_finals = "PQRSABCDHF";
    string             csi_finals = "ABCDHFZ";

    terminal_key_sequence_decoder_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(negedge clk)
        m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                observed_key.key        = m_axis_tdata[4:0];
                observed_key.char_bytes = m_axis_tdata[36:5];
                observed_key.char_len   = m_axis_tdata[39:37];
                observed_key.last       = m_axis_tlast;
                sb.check_key(observed_key);
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("terminal_key_sequence_decoder_core regression: fail");
        $finish;
    end

    // Offers one input transaction, with an optional gap before it, and returns once taken.
    task automatic send_item(input bit op, input logic [7:0] data, input bit counted);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = 8'($urandom_range(0, 255));
            s_axis_tuser  = 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = data;
        s_axis_tuser  = op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (counted)
            stim_items++;
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_item(OP_BYTE, data, 1'b1);
    endtask

    task automatic send_timeout(input bit counted);
        send_item(OP_TIMEOUT, 8'($urandom_range(0, 255)), counted);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_keys.size() > 0)
            @(posedge clk);
    endtask

    // One random sequence: mostly well-formed escapes and characters, some noise.
    task automatic gen_sequence();
        int    pick;
        int    v;
        int    num;
        int    follow;
        string digits;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            send_byte(8'($urandom_range(8'h20, 8'h7E)));
        else if (pick < 20)
        begin
            if ($urandom_range(0, 9) == 0)
                send_byte(DEL_BYTE);
            else
                send_byte(8'($urandom_range(0, 31)));
        end
        else if (pick < 25)
        begin
            send_byte(ESC_BYTE);
            send_timeout(1'b1);
        end
        else if (pick < 38)
        begin
            send_byte(ESC_BYTE);
            send_byte("O");
            v = $urandom_range(0, 19);
            if (v == 0)
                send_timeout(1'b1);
            else if (v < 15)
                send_byte(ss3_finals[$urandom_range(0, 9)]);
            else
                send_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 68)
        begin
            send_byte(ESC_BYTE);
            send_byte("[");
            if ($urandom_range(0, 9) == 0)
            begin
                // Long parameter runs can push past the byte limit of the number.
                repeat ($urandom_range(10, 24))
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_byte(8'($urandom_range(8'h7F, 8'hFF)));
                    else
                        send_byte(8'($urandom_range(0, 8'h3F)));
                end
            end
            else
            begin
                repeat ($urandom_range(0, 2))
                begin
                    v = $urandom_range(8, 13);
                    send_byte((v == 8) ? 8'd32 : 8'(v));
                end
                v = $urandom_range(0, 7);
                if (v == 0)
                    send_byte("+");
                else if (v == 1)
                    send_byte("-");
                v = $urandom_range(0, 9);
                if (v < 6)
                    num = tilde_codes[$urandom_range(0, 19)];
                else if (v < 9)
                    num = $urandom_range(0, 99999);
                else
                    num = -1;
                if (num >= 0)
                begin
                    digits = $sformatf("%0d", num);
                    if ($urandom_range(0, 4) == 0)
                        digits = {"0", digits};
                    for (int i = 0; i < digits.len(); i++)
                        send_byte(digits[i]);
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    send_byte(";");
                    send_byte(8'($urandom_range(8'h30, 8'h39)));
                end
            end
            v = $urandom_range(0, 19);
            if (v == 0)
                send_timeout(1'b1);
            else if (v < 10)
                send_byte("~");
            else if (v < 17)
                send_byte(csi_finals[$urandom_range(0, 6)]);
            else
                send_byte(8'($urandom_range(8'h40, 8'h7E)));
        end
        else if (pick < 80)
        begin
            follow = $urandom_range(1, 3);
            case (follow)
                1:       send_byte(8'($urandom_range(8'hC0, 8'hDF)));
                2:       send_byte(8'($urandom_range(8'hE0, 8'hEF)));
                default: send_byte(8'($urandom_range(8'hF0, 8'hF7)));
            endcase
            for (int i = 0; i < follow; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_timeout(1'b1);
                    break;
                end
                if ($urandom_range(0, 4) == 0)
                    send_byte(8'($urandom_range(0, 255)));
                else
                    send_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
        end
        else if (pick < 88)
        begin
            send_byte(ESC_BYTE);
            send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                send_timeout(1'b0);
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int  target;
        bit  paused;
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 13;
        recv_idle_pct = 88;

        // Directed: idle timeout, byte extremes, named keys and each escape outcome.
        send_timeout(1'b0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'd13);
        send_byte(DEL_BYTE);
        send_byte(ESC_BYTE);
        send_timeout(1'b1);
        send_byte(ESC_BYTE);
        send_byte("O");
        send_byte("P");
        send_byte(ESC_BYTE);
        send_byte("[");
        send_byte("2");
        send_byte("4");
        send_byte("~");
        send_byte(ESC_BYTE);
        send_byte("[");
        send_byte("-");
        send_byte("3");
        send_byte("~");
        send_byte(ESC_BYTE);
        send_byte("x");
        send_byte(8'hF0);
        send_byte(8'h9F);
        send_timeout(1'b1);

        for (int pass = 0; pass < 3; pass++)
        begin
            case (pass)
                0:
                begin
                    send_idle_pct = 13;
                    recv_idle_pct = 88;
                end
                1:
                begin
                    send_idle_pct = 88;
                    recv_idle_pct = 13;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = stim_items + ITEMS_PER_PASS;
            paused = 1'b0;
            while (stim_items < target)
            begin
                gen_sequence();
                if (!paused && stim_items >= target - ITEMS_PER_PASS / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_keys.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d input transactions and checked %0d key transactions, %0d mismatches.",
                 sb.inputs_seen, sb.keys_checked, sb.mismatches);
        $display("Plain, control, SS3, CSI, stray-escape and UTF-8 input reached %0d key codes.",
                 $countones(sb.keys_seen));
        if (sb.mismatches == 0 && sb.expected_keys.size() == 0)
            $display("terminal_key_sequence_decoder_core regression: pass");
        else
            $display("terminal_key_sequence_decoder_core regression: fail");
        $finish;
    end

endmodule
